@@ hw/rtl/ble_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ble_pkg
// Shared types and constants for the budgeted LRU evictor.
// ----------------------------------------------------------------------------
package ble_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned BytesW = 40;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned TotalW = 45;

  localparam logic [BytesW-1:0] DefaultLimit = 40'd21474836480;

  localparam logic [1:0] CmdCreate = 2'd0;
  localparam logic [1:0] CmdAccess = 2'd1;
  localparam logic [1:0] CmdDelete = 2'd2;
  localparam logic [1:0] CmdClear  = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  localparam logic EvRemoved  = 1'b0;
  localparam logic EvFinished = 1'b1;

  // One table entry as it travels along the cell chain.
  typedef struct packed {
    logic              valid;
    logic [KeyW-1:0]   key;
    logic [BytesW-1:0] bytes;
    logic [TimeW-1:0]  stamp;
  } entry_t;

endpackage
`default_nettype wire

@@ hw/rtl/ble_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ble_cell
// One table slot of the rotating chain; loads its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module ble_cell
  import ble_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   shift_i,
  input  wire entry_t entry_i,
  output entry_t      entry_o
);

  logic   valid_q;
  entry_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= entry_i;
    end
  end

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end

endmodule
`default_nettype wire

@@ hw/rtl/budgeted_lru_evictor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// budgeted_lru_evictor
// LRU object table with a byte budget; create, access, delete and clear.
// ----------------------------------------------------------------------------
// The table is a ring of TABLE_DEPTH cells that rotates one slot per cycle;
// the head cell is examined as it passes. Access and delete take one
// lookup pass; create takes a lookup pass, a free-slot pass when the key
// is new, a search pass unless the table is full, then one removal pass
// and one further search pass per eviction; clear takes one pass. Each
// command ends in a finished result, registered in a done state after its
// last pass. Results appear one cycle wide on event_kind_o etc. with
// result_valid_o and cannot be stalled; busy_o falls in the cycle the
// finished result (last_o) is shown.
module budgeted_lru_evictor
  import ble_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        command_i,
  input  wire logic [KeyW-1:0]   object_key_i,
  input  wire logic [BytesW-1:0] object_bytes_i,
  input  wire logic [TimeW-1:0]  now_time_i,
  input  wire logic              cfg_we_i,
  input  wire logic [BytesW-1:0] cfg_wdata_i,
  output logic                   result_valid_o,
  output logic                   event_kind_o,
  output logic [KeyW-1:0]        removed_key_o,
  output logic [1:0]             status_o,
  output logic                   budget_warning_o,
  output logic [TotalW-1:0]      total_bytes_o,
  output logic                   last_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH);
  localparam logic [CntW-1:0] CntMax = CntW'(TABLE_DEPTH - 1);
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE, S_LOOKUP, S_FREE, S_SEARCH, S_REMOVE, S_CLEAR, S_DONE
  } state_e;

  state_e state_q;
  logic [CntW-1:0]   cnt_q;
  logic [1:0]        cmd_q;
  logic [KeyW-1:0]   key_q;
  logic [BytesW-1:0] bytes_q;
  logic [TimeW-1:0]  now_q;
  logic [BytesW-1:0] limit_q;
  logic [TotalW-1:0] total_q;
  logic              found_q, best_ok_q;
  logic [CntW-1:0]   best_pos_q;
  logic [TimeW-1:0]  best_time_q;
  logic [KeyW-1:0]   best_key_q;
  logic [1:0]        st_q;

  entry_t chain [TABLE_DEPTH];
  entry_t head, head_new;
  logic   shift;

  assign head = chain[0];
  assign shift = (state_q == S_LOOKUP) || (state_q == S_FREE) ||
                 (state_q == S_SEARCH) || (state_q == S_REMOVE) ||
                 (state_q == S_CLEAR);

  // cell i takes cell i+1; last cell takes possibly updated head
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    entry_t nxt;
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign nxt = head_new;
    end else begin : g_mid
      assign nxt = chain[g+1];
    end
    ble_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (nxt),
      .entry_o (chain[g])
    );
  end

  logic head_hit, head_older;
  assign head_hit = head.valid && (head.key == key_q);
  assign head_older = !best_ok_q || (head.stamp < best_time_q) ||
                      ((head.stamp == best_time_q) && (head.key < best_key_q));

  logic [TotalW-1:0] sub_res, add_res;
  logic [TotalW:0]   add_wide;
  assign sub_res  = (TotalW'(head.bytes) > total_q) ? '0 : total_q - TotalW'(head.bytes);
  assign add_wide = {1'b0, total_q} + (TotalW+1)'(bytes_q);
  assign add_res  = add_wide[TotalW] ? TotalMax : add_wide[TotalW-1:0];

  always_comb begin
    head_new = head;
    unique case (state_q)
      S_LOOKUP: begin
        if (head_hit && !found_q) begin
          if (cmd_q == CmdCreate) begin
            head_new.bytes = bytes_q;
            head_new.stamp = now_q;
          end else if (cmd_q == CmdAccess) begin
            head_new.stamp = now_q;
          end else begin
            head_new.valid = 1'b0;
          end
        end
      end
      S_FREE: begin
        if (!head.valid && !found_q) begin
          head_new.valid = 1'b1;
          head_new.key   = key_q;
          head_new.bytes = bytes_q;
          head_new.stamp = now_q;
        end
      end
      S_REMOVE: begin
        if (cnt_q == best_pos_q) head_new.valid = 1'b0;
      end
      S_CLEAR: head_new.valid = 1'b0;
      default: ;
    endcase
  end

  logic over;
  assign over = total_q > TotalW'(limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      limit_q <= DefaultLimit;
      total_q <= '0;
      found_q <= 1'b0;
      best_ok_q <= 1'b0;
      result_valid_o <= 1'b0;
      event_kind_o <= EvFinished;
      removed_key_o <= '0;
      status_o <= StOk;
      budget_warning_o <= 1'b0;
      total_bytes_o <= '0;
      last_o <= 1'b0;
      cmd_q <= CmdCreate;
      key_q <= '0;
      bytes_q <= '0;
      now_q <= '0;
      best_pos_q <= '0;
      best_time_q <= '0;
      best_key_q <= '0;
      st_q <= StOk;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (shift) cnt_q <= (cnt_q == CntMax) ? '0 : cnt_q + 1'b1;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cmd_q <= command_i;
            key_q <= object_key_i;
            bytes_q <= object_bytes_i;
            now_q <= now_time_i;
            found_q <= 1'b0;
            cnt_q <= '0;
            st_q <= StOk;
            state_q <= (command_i == CmdClear) ? S_CLEAR : S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (head_hit && !found_q) begin
            found_q <= 1'b1;
            if (cmd_q == CmdCreate) begin
              total_q <= sub_res;
            end else if (cmd_q == CmdDelete) begin
              total_q <= sub_res;
              result_valid_o <= 1'b1;
              event_kind_o <= EvRemoved;
              removed_key_o <= head.key;
              status_o <= StOk;
              budget_warning_o <= 1'b0;
              total_bytes_o <= sub_res;
              last_o <= 1'b0;
            end
          end
          if (cnt_q == CntMax) begin
            if (cmd_q == CmdCreate) begin
              if (found_q || head_hit) begin
                // total already reduced; add happens here at pass end
                total_q <= add_wide[TotalW] ? TotalMax : add_res;
                if (head_hit && !found_q) begin
                  total_q <= ((TotalW+1)'(sub_res) + (TotalW+1)'(bytes_q) > (TotalW+1)'(TotalMax))
                             ? TotalMax : sub_res + TotalW'(bytes_q);
                end
                best_ok_q <= 1'b0;
                state_q <= S_SEARCH;
              end else begin
                state_q <= S_FREE;
              end
            end else begin
              if (!found_q && !head_hit) st_q <= StNotFound;
              state_q <= S_DONE;
            end
          end
        end
        S_FREE: begin
          if (!head.valid && !found_q) found_q <= 1'b1;
          if (cnt_q == CntMax) begin
            if (found_q || !head.valid) begin
              total_q <= add_res;
              best_ok_q <= 1'b0;
              state_q <= S_SEARCH;
            end else begin
              st_q <= StFull;
              state_q <= S_DONE;
            end
          end
        end
        S_SEARCH: begin
          // search pass also decides whether any eviction is needed
          if (head.valid && head_older) begin
            best_ok_q <= 1'b1;
            best_pos_q <= cnt_q;
            best_time_q <= head.stamp;
            best_key_q <= head.key;
          end
          if (cnt_q == CntMax) begin
            if (over && (best_ok_q || head.valid)) state_q <= S_REMOVE;
            else state_q <= S_DONE;
          end
        end
        S_REMOVE: begin
          if (cnt_q == best_pos_q) begin
            total_q <= sub_res;
            result_valid_o <= 1'b1;
            event_kind_o <= EvRemoved;
            removed_key_o <= head.key;
            status_o <= StOk;
            budget_warning_o <= 1'b1;
            total_bytes_o <= sub_res;
            last_o <= 1'b0;
          end
          if (cnt_q == CntMax) begin
            best_ok_q <= 1'b0;
            state_q <= S_SEARCH;
          end
        end
        S_CLEAR: begin
          if (head.valid) begin
            total_q <= sub_res;
            result_valid_o <= 1'b1;
            event_kind_o <= EvRemoved;
            removed_key_o <= head.key;
            status_o <= StOk;
            budget_warning_o <= 1'b0;
            total_bytes_o <= sub_res;
            last_o <= 1'b0;
          end
          if (cnt_q == CntMax) state_q <= S_DONE;
        end
        S_DONE: begin
          result_valid_o <= 1'b1;
          event_kind_o <= EvFinished;
          removed_key_o <= '0;
          status_o <= st_q;
          budget_warning_o <= 1'b0;
          total_bytes_o <= total_q;
          last_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  a_last_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> event_kind_o == EvFinished)
    else $error("last result not a finished event");
  a_warn_removal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && budget_warning_o |-> event_kind_o == EvRemoved && !last_o)
    else $error("budget warning on non-removal");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy_o)
    else $error("busy after finished result");
`endif

endmodule
`default_nettype wire
